// ----- hw/rtl/nopm_pkg.sv -----
// ----------------------------------------------------------------------------
// nopm_pkg
// shared types and constants of the note on/off pair matcher
// ----------------------------------------------------------------------------
package nopm_pkg;

   localparam int TICK_W = 32;
   localparam int IDX_W  = 16;
   localparam int KIND_W = 2;
   localparam int NOTE_W = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // event kinds
   localparam logic [KIND_W-1:0] KIND_ON  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OFF = 2'd1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MATCH_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOTE_PITCH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_IDX  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_START  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPAN_END    = 3'd4;

   // broadcast from the controller to every stack cell
   typedef struct packed {
      logic              off_idx;        // note-off beat in index mode
      logic              any_hit;        // some cell holds an earlier tick
      logic [TICK_W-1:0] event_tick;
      logic [IDX_W-1:0]  event_pos;
      logic [IDX_W-1:0]  target_on_index;
      logic [TICK_W-1:0] span_start_tick;
   } cell_ctrl_type;

   // per-cell status back to the controller
   typedef struct packed {
      logic match_idx;   // selected entry sits at the target position
      logic match_top;   // top entry carries the start tick
   } cell_stat_type;

endpackage

// ----- hw/rtl/nopm_cell.sv -----
// ----------------------------------------------------------------------------
// nopm_cell
// one entry of the open note-on stack with its own tick compare
// ----------------------------------------------------------------------------
module nopm_cell (
   input  logic                             clock,
   input  nopm_pkg::cell_ctrl_type          ctrl,
   input  logic                             occ,
   input  logic                             occ_above,
   input  logic                             push_here,
   input  logic [nopm_pkg::TICK_W-1:0]      up_tick,
   input  logic [nopm_pkg::IDX_W-1:0]       up_pos,
   input  logic                             hit_above_in,
   output logic                             hit_above_out,
   output logic [nopm_pkg::TICK_W-1:0]      tick_out,
   output logic [nopm_pkg::IDX_W-1:0]       pos_out,
   output nopm_pkg::cell_stat_type          stat
);

   logic [nopm_pkg::TICK_W-1:0] tick_ff, tick_in;
   logic [nopm_pkg::IDX_W-1:0]  pos_ff, pos_in;
   logic                        hit, sel, shift, top;

   always_comb begin
      hit            = occ && (ctrl.event_tick > tick_ff);
      hit_above_out  = hit || hit_above_in;
      sel            = hit && !hit_above_in;
      // cells at or above the removed entry take their upper neighbor
      shift          = ctrl.off_idx && ctrl.any_hit && !hit_above_in;
      top            = occ && !occ_above;
      stat.match_idx = sel && (pos_ff == ctrl.target_on_index);
      stat.match_top = top && (tick_ff == ctrl.span_start_tick);
      tick_in        = tick_ff;
      pos_in         = pos_ff;
      if (push_here) begin
         tick_in = ctrl.event_tick;
         pos_in  = ctrl.event_pos;
      end else if (shift) begin
         tick_in = up_tick;
         pos_in  = up_pos;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      pos_ff  <= pos_in;
   end

   assign tick_out = tick_ff;
   assign pos_out  = pos_ff;

endmodule

// ----- hw/rtl/note_on_off_pair_matcher.sv -----
// ----------------------------------------------------------------------------
// note_on_off_pair_matcher
// pairs note-ons with note-offs of one pitch on a shift stack of cells
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    event_kind note_number note_velocity
//                                       event_tick last_event
//  rsp      out  rsp_valid/rsp_ready    pair_found off_index stack_overflowed
//  csr      in   csr_we                 csr_index csr_wdata
//
//  one event beat per cycle; each stack cell compares its tick in parallel
//  and the removal shift happens in the same cycle
//  a result sits in the output register; req_ready drops only while a
//  result is held back by rsp_ready low
//  reset clears stack count, position, done and overflow flags and the
//  registers; stack contents are left as they are
// ----------------------------------------------------------------------------
module note_on_off_pair_matcher #(
   parameter int STACK_DEPTH = 16,
   parameter int MAX_EVENTS  = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   // event beats
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [nopm_pkg::KIND_W-1:0]       req_event_kind,
   input  logic [nopm_pkg::NOTE_W-1:0]       req_note_number,
   input  logic [nopm_pkg::NOTE_W-1:0]       req_note_velocity,
   input  logic [nopm_pkg::TICK_W-1:0]       req_event_tick,
   input  logic                              req_last_event,
   // result beats
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_pair_found,
   output logic [nopm_pkg::IDX_W-1:0]        rsp_off_index,
   output logic                              rsp_stack_overflowed,
   // register writes
   input  logic                              csr_we,
   input  logic [nopm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nopm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int POS_W = $clog2(MAX_EVENTS);

   // configuration registers
   logic                          match_mode_ff;
   logic [nopm_pkg::NOTE_W-1:0]   note_pitch_ff;
   logic [nopm_pkg::IDX_W-1:0]    target_on_index_ff;
   logic [nopm_pkg::TICK_W-1:0]   span_start_tick_ff;
   logic [nopm_pkg::TICK_W-1:0]   span_end_tick_ff;

   // scan state
   logic [CNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             done_ff, done_in;
   logic             ovf_ff, ovf_in;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        found_ff, found_in;
   logic [nopm_pkg::IDX_W-1:0]  off_index_ff, off_index_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   // stack chain wiring
   nopm_pkg::cell_ctrl_type     ctrl;
   nopm_pkg::cell_stat_type     stat [STACK_DEPTH];
   logic [nopm_pkg::TICK_W-1:0] cell_tick [STACK_DEPTH];
   logic [nopm_pkg::IDX_W-1:0]  cell_pos [STACK_DEPTH];
   logic [STACK_DEPTH-1:0]      hit_out;
   logic [STACK_DEPTH-1:0]      match_idx_vec;
   logic [STACK_DEPTH-1:0]      match_top_vec;

   logic                        accept, step, is_on, is_off, full, push, pitch_ok;
   logic                        found, report;
   logic [nopm_pkg::IDX_W-1:0]  pos16;

   // ---------------------------------------------------------------------
   // register writes, unknown indexes are dropped
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         match_mode_ff      <= 1'b0;
         note_pitch_ff      <= '0;
         target_on_index_ff <= '0;
         span_start_tick_ff <= '0;
         span_end_tick_ff   <= '0;
      end else if (csr_we) begin
         case (csr_index)
            nopm_pkg::CSR_MATCH_MODE: begin
               match_mode_ff <= csr_wdata[0];
            end
            nopm_pkg::CSR_NOTE_PITCH: begin
               note_pitch_ff <= csr_wdata[nopm_pkg::NOTE_W-1:0];
            end
            nopm_pkg::CSR_TARGET_IDX: begin
               target_on_index_ff <= csr_wdata[nopm_pkg::IDX_W-1:0];
            end
            nopm_pkg::CSR_SPAN_START: begin
               span_start_tick_ff <= csr_wdata[nopm_pkg::TICK_W-1:0];
            end
            nopm_pkg::CSR_SPAN_END: begin
               span_end_tick_ff <= csr_wdata[nopm_pkg::TICK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // event decode
   // ---------------------------------------------------------------------
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   // beats after a match are swallowed until the last one
   assign step      = accept && !done_ff;
   assign pitch_ok  = (req_note_number == note_pitch_ff);
   assign is_on     = (req_event_kind == nopm_pkg::KIND_ON) &&
                      (req_note_velocity != '0) && pitch_ok;
   // velocity zero on a note-on means note-off
   assign is_off    = ((req_event_kind == nopm_pkg::KIND_OFF) ||
                       ((req_event_kind == nopm_pkg::KIND_ON) &&
                        (req_note_velocity == '0))) && pitch_ok;
   assign full      = (count_ff == CNT_W'(STACK_DEPTH));
   assign push      = step && is_on && !full;
   // positions are kept and reported in their low 16 bits
   assign pos16     = nopm_pkg::IDX_W'(pos_ff);

   always_comb begin
      ctrl.off_idx         = step && is_off && !match_mode_ff && (count_ff != '0);
      ctrl.any_hit         = hit_out[0];
      ctrl.event_tick      = req_event_tick;
      ctrl.event_pos       = pos16;
      ctrl.target_on_index = target_on_index_ff;
      ctrl.span_start_tick = span_start_tick_ff;
   end

   // ---------------------------------------------------------------------
   // stack cells, index 0 is the bottom; the hit flag ripples downward
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic                        occ, occ_above, push_here, hit_above_in;
      logic [nopm_pkg::TICK_W-1:0] up_tick;
      logic [nopm_pkg::IDX_W-1:0]  up_pos;

      assign occ       = (count_ff > CNT_W'(i));
      assign push_here = push && (count_ff == CNT_W'(i));

      if (i == STACK_DEPTH - 1) begin : g_top
         assign occ_above    = 1'b0;
         assign hit_above_in = 1'b0;
         assign up_tick      = cell_tick[i];
         assign up_pos       = cell_pos[i];
      end else begin : g_mid
         assign occ_above    = (count_ff > CNT_W'(i + 1));
         assign hit_above_in = hit_out[i+1];
         assign up_tick      = cell_tick[i+1];
         assign up_pos       = cell_pos[i+1];
      end

      nopm_cell u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .occ           (occ),
         .occ_above     (occ_above),
         .push_here     (push_here),
         .up_tick       (up_tick),
         .up_pos        (up_pos),
         .hit_above_in  (hit_above_in),
         .hit_above_out (hit_out[i]),
         .tick_out      (cell_tick[i]),
         .pos_out       (cell_pos[i]),
         .stat          (stat[i])
      );

      assign match_idx_vec[i] = stat[i].match_idx;
      assign match_top_vec[i] = stat[i].match_top;
   end

   // ---------------------------------------------------------------------
   // scan control
   // ---------------------------------------------------------------------
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      done_in      = done_ff;
      ovf_in       = ovf_ff;
      found        = 1'b0;
      report       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      found_in     = found_ff;
      off_index_in = off_index_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (accept && done_ff) begin
         // matched already, wait for the closing beat
         if (req_last_event) begin
            count_in = '0;
            pos_in   = '0;
            done_in  = 1'b0;
            ovf_in   = 1'b0;
         end
      end else if (step) begin
         if (is_on) begin
            if (full) begin
               ovf_in = 1'b1;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (is_off && (count_ff != '0)) begin
            if (!match_mode_ff) begin
               // topmost earlier note-on is pulled out of the stack
               if (hit_out[0]) begin
                  found    = |match_idx_vec;
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               found    = (|match_top_vec) && (req_event_tick == span_end_tick_ff);
               count_in = count_ff - CNT_W'(1);
            end
         end

         if (pos_ff != POS_W'(MAX_EVENTS - 1)) begin
            pos_in = pos_ff + POS_W'(1);
         end

         report = found || req_last_event;
         if (report) begin
            rsp_valid_in = 1'b1;
            found_in     = found;
            off_index_in = found ? pos16 : '0;
            rsp_ovf_in   = ovf_in;
            if (req_last_event) begin
               count_in = '0;
               pos_in   = '0;
               done_in  = 1'b0;
               ovf_in   = 1'b0;
            end else begin
               done_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pos_ff       <= '0;
         done_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         done_ff      <= done_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      found_ff     <= found_in;
      off_index_ff <= off_index_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pair_found       = found_ff;
   assign rsp_off_index        = off_index_ff;
   assign rsp_stack_overflowed = rsp_ovf_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_one_selected: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_idx_vec) && $onehot0(match_top_vec))
      else $error("more than one stack entry selected");

   a_no_pair_zero_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !found_ff |-> off_index_ff == '0)
      else $error("off index set without a pair");

   a_done_frozen: assert property (@(posedge clock) disable iff (reset)
      accept && done_ff && !req_last_event |=> $stable(count_ff) && done_ff)
      else $error("stack moved after a match");

endmodule
